FILE: rtl/core/msstk_pkg.sv
// shared types and constants for the mask snapshot stack
package msstk_pkg;

  localparam int SLOT_W  = 6;
  localparam int MASK_W  = 8;
  localparam int REQ_W   = 3;
  localparam int LVL_O_W = 2;
  localparam int STAT_W  = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LEVEL   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SAVE    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RESTORE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_WRITE   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ    = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH,
    OP_POP,
    OP_SAVE,
    OP_RESTORE,
    OP_WRITE
  } msstk_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DONE
  } msstk_state_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [SLOT_W-1:0] slot;
    logic [MASK_W-1:0] mask_value;
    logic              slot_allocated;
  } msstk_req_t;

  typedef struct packed {
    logic [MASK_W-1:0]  slot_mask;
    logic [LVL_O_W-1:0] stack_level;
    logic [STAT_W-1:0]  status;
  } msstk_rsp_t;

endpackage

FILE: rtl/core/msstk_cell.sv
// one ring cell: a slot's mask, allocated flag and snapshot column
module msstk_cell #(
  parameter int STACK_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               shift_en,
  input  logic [msstk_pkg::MASK_W-1:0]       mask_in,
  input  logic                               alloc_in,
  input  logic [STACK_DEPTH-1:0][msstk_pkg::MASK_W-1:0] snap_in,
  output logic [msstk_pkg::MASK_W-1:0]       mask_out,
  output logic                               alloc_out,
  output logic [STACK_DEPTH-1:0][msstk_pkg::MASK_W-1:0] snap_out
);
  import msstk_pkg::*;

  logic [MASK_W-1:0]                   mask_r;
  logic                                alloc_r;
  logic [STACK_DEPTH-1:0][MASK_W-1:0]  snap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      alloc_r <= 1'b0;
      snap_r  <= '0;
    end else if (shift_en) begin
      mask_r  <= mask_in;
      alloc_r <= alloc_in;
      snap_r  <= snap_in;
    end
  end

  assign mask_out  = mask_r;
  assign alloc_out = alloc_r;
  assign snap_out  = snap_r;

endmodule

FILE: rtl/core/mask_snapshot_stack.sv
// top level: per-slot skip masks with a stack of whole-table snapshots
//
//  port group   dir  handshake           payload
//  in_*         in   in_valid/in_stall   msstk_req_t (req_type, slot, mask_value, slot_allocated)
//  out_*        out  out_valid/out_stall msstk_rsp_t (slot_mask, stack_level, status)
//
// every item passes through an accept step, a turn in which the ring of slot
// cells turns once past the head logic, and a done state with the result held
// in the output register
// one item is in flight at a time; in_stall is high from accept until the
// result is taken, so a stalled result holds off the next item
// synchronous reset clears all masks, flags, snapshots and the level at once
module mask_snapshot_stack #(
  parameter int NUM_TASKS   = 64,
  parameter int STACK_DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  msstk_pkg::msstk_req_t   in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output msstk_pkg::msstk_rsp_t   out_data
);
  import msstk_pkg::*;

  localparam int IDX_W = $clog2(NUM_TASKS);
  localparam int LVL_W = $clog2(STACK_DEPTH);
  localparam int CMP_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
  localparam logic [LVL_W-1:0] LVL_TOP  = LVL_W'(STACK_DEPTH - 1);
  localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(NUM_TASKS - 1);

  // ring wiring: cell i feeds cell i-1, cell 0 feeds the head, head feeds the last cell
  logic [MASK_W-1:0]                   c_mask  [NUM_TASKS];
  logic                                c_alloc [NUM_TASKS];
  logic [STACK_DEPTH-1:0][MASK_W-1:0]  c_snap  [NUM_TASKS];

  // head output (record of slot cnt_r after this item's update)
  logic [MASK_W-1:0]                   h_mask;
  logic                                h_alloc;
  logic [STACK_DEPTH-1:0][MASK_W-1:0]  h_snap;

  logic shift_en;

  // control and item registers
  msstk_state_t       state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  msstk_op_t          op_r, op_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic               ok_r, ok_nxt;
  logic [MASK_W-1:0]  val_r, val_nxt;
  logic               alloc_r, alloc_nxt;
  logic [LVL_W-1:0]   level_r, level_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [MASK_W-1:0]  out_mask_r, out_mask_nxt;

  logic [LVL_W-1:0]   lvl_up;
  logic               hit;
  logic [LVL_W+1:0]   lvl_wide;

  genvar gi;
  generate
    for (gi = 0; gi < NUM_TASKS; gi++) begin : g_ring
      if (gi == NUM_TASKS - 1) begin : g_tail
        msstk_cell #(.STACK_DEPTH(STACK_DEPTH)) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (shift_en),
          .mask_in  (h_mask),
          .alloc_in (h_alloc),
          .snap_in  (h_snap),
          .mask_out (c_mask[gi]),
          .alloc_out(c_alloc[gi]),
          .snap_out (c_snap[gi])
        );
      end else begin : g_body
        msstk_cell #(.STACK_DEPTH(STACK_DEPTH)) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (shift_en),
          .mask_in  (c_mask[gi+1]),
          .alloc_in (c_alloc[gi+1]),
          .snap_in  (c_snap[gi+1]),
          .mask_out (c_mask[gi]),
          .alloc_out(c_alloc[gi]),
          .snap_out (c_snap[gi])
        );
      end
    end
  endgenerate

  // the record passing the head during turn step k belongs to slot k
  assign hit    = ok_r && (CMP_W'(cnt_r) == CMP_W'(slot_r));
  assign lvl_up = level_r + LVL_W'(1);

  // head: apply the item's operation to the record leaving cell 0
  always_comb begin
    h_mask  = c_mask[0];
    h_alloc = c_alloc[0];
    h_snap  = c_snap[0];
    case (op_r)
      OP_PUSH: begin
        // snapshot every slot, exempt one included, into the new level
        h_snap[lvl_up] = c_mask[0];
        if (!hit) begin
          h_mask = c_alloc[0] ? (c_mask[0] | val_r) : '0;
        end
      end
      OP_POP: begin
        if (!hit) begin
          h_mask = c_snap[0][level_r];
        end
      end
      OP_SAVE: begin
        if (hit) begin
          h_snap[level_r] = c_mask[0];
        end
      end
      OP_RESTORE: begin
        if (hit) begin
          h_mask = c_snap[0][level_r];
        end
      end
      OP_WRITE: begin
        if (hit) begin
          h_mask  = val_r;
          h_alloc = alloc_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      op_r     <= OP_NOP;
      level_r  <= '0;
      status_r <= ST_OK;
      ok_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      op_r     <= op_nxt;
      level_r  <= level_nxt;
      status_r <= status_nxt;
      ok_r     <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    val_r      <= val_nxt;
    alloc_r    <= alloc_nxt;
    out_mask_r <= out_mask_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    op_nxt       = op_r;
    slot_nxt     = slot_r;
    ok_nxt       = ok_r;
    val_nxt      = val_r;
    alloc_nxt    = alloc_r;
    level_nxt    = level_r;
    status_nxt   = status_r;
    out_mask_nxt = out_mask_r;
    shift_en     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          slot_nxt     = in_data.slot;
          val_nxt      = in_data.mask_value;
          alloc_nxt    = in_data.slot_allocated;
          ok_nxt       = CMP_W'(in_data.slot) < CMP_W'(NUM_TASKS);
          out_mask_nxt = '0;  // stays zero for a slot past the table
          cnt_nxt      = '0;
          status_nxt   = ST_OK;
          op_nxt       = OP_NOP;
          case (in_data.req_type)
            REQ_LEVEL: begin
              if (in_data.mask_value == '0) begin
                if (level_r == '0) begin
                  status_nxt = ST_UNDERFLOW;
                end else begin
                  op_nxt = OP_POP;
                end
              end else if (level_r == LVL_TOP) begin
                status_nxt = ST_OVERFLOW;
              end else begin
                op_nxt = OP_PUSH;
              end
            end
            REQ_SAVE:    op_nxt = OP_SAVE;
            REQ_RESTORE: op_nxt = OP_RESTORE;
            REQ_WRITE:   op_nxt = OP_WRITE;
            default:     op_nxt = OP_NOP;  // read and unknown codes
          endcase
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        shift_en = 1'b1;
        if (hit) begin
          out_mask_nxt = h_mask;
        end
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DONE;
          case (op_r)
            OP_PUSH: level_nxt = lvl_up;
            OP_POP:  level_nxt = level_r - LVL_W'(1);
            default: level_nxt = level_r;
          endcase
        end
      end
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  assign lvl_wide              = {2'b00, level_r};
  assign out_data.slot_mask    = out_mask_r;
  assign out_data.stack_level  = lvl_wide[LVL_O_W-1:0];
  assign out_data.status       = status_r;

  // only one item in flight: no input taken while a result waits
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while result pending");

  // a full turn of the ring always ends in the result state
  a_turn_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && cnt_r == CNT_LAST) |=> out_valid)
    else $error("ring turn did not finish");

  // level stays inside the snapshot stack
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_TOP)
    else $error("level beyond stack depth");

  // a refused push or pop leaves the level where it was
  a_err_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && status_r != ST_OK) |=> $stable(level_r))
    else $error("level moved on overflow or underflow");

  // the turn counter is parked at zero when a turn starts
  a_cnt_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (cnt_r == '0))
    else $error("turn counter not cleared on accept");

endmodule

FILE: bench/testbench.sv
// testbench for mask_snapshot_stack: directed and random requests against a table predictor
module testbench;
  import msstk_pkg::*;

  localparam int TASKS            = 64;
  localparam int DEPTH            = 4;
  // the tail is a little longer than one item takes
  localparam int TAIL_CYCLES      = TASKS + 10;
  // about 875 items plus long gaps and stalls stays far below this
  localparam int CYCLE_LIMIT      = 600000;
  localparam int NUM_PHASES       = 4;
  localparam int RANDOM_PER_PHASE = 213;
  // request codes above REQ_READ are spare and must leave the table alone
  localparam logic [REQ_W-1:0]  REQ_TOP   = 3'd7;
  // a level request with a zero value pops
  localparam logic [MASK_W-1:0] POP_VALUE = '0;
  localparam logic [MASK_W-1:0] ALL_ONES  = '1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASKS - 1);

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  msstk_req_t in_data;
  logic       out_valid;
  logic       out_stall;
  msstk_rsp_t out_data;

  // predicted copy of the slot table and its snapshot stack
  logic [MASK_W-1:0] slot_masks [TASKS];
  logic              alloc_bits [TASKS];
  logic [MASK_W-1:0] snapshots  [DEPTH][TASKS];
  int                table_level;

  msstk_req_t request_queue [$];   // items still to be offered
  msstk_rsp_t awaited_results [$]; // predicted results, oldest first

  logic in_taken;      // the offered item was accepted at the last rising edge
  int   idle_pct;      // chance that the sender holds off an item
  int   stall_pct;     // chance that the receiver stalls a cycle
  int   fails;
  int   cycle_count;

  mask_snapshot_stack #(
    .NUM_TASKS  (TASKS),
    .STACK_DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // advance the predicted table by one request and return the result it gives
  function automatic msstk_rsp_t step_mask_table(msstk_req_t r);
    msstk_rsp_t        rsp;
    logic [MASK_W-1:0] keep;
    logic [STAT_W-1:0] st;
    int                i;
    st   = ST_OK;
    // the exempt slot's mask survives a push or pop untouched
    keep = slot_masks[r.slot];
    case (r.req_type)
      REQ_LEVEL: begin
        if (r.mask_value == POP_VALUE) begin
          if (table_level == 0) begin
            st = ST_UNDERFLOW;
          end else begin
            for (i = 0; i < TASKS; i++) slot_masks[i] = snapshots[table_level][i];
            table_level--;
            slot_masks[r.slot] = keep;
          end
        end else if (table_level == DEPTH - 1) begin
          st = ST_OVERFLOW;
        end else begin
          // snapshot goes into the row of the new level, then free slots clear and allocated ones OR in the value
          table_level++;
          for (i = 0; i < TASKS; i++) begin
            snapshots[table_level][i] = slot_masks[i];
            slot_masks[i] = alloc_bits[i] ? (slot_masks[i] | r.mask_value) : '0;
          end
          slot_masks[r.slot] = keep;
        end
      end
      REQ_SAVE:    snapshots[table_level][r.slot] = slot_masks[r.slot];
      REQ_RESTORE: slot_masks[r.slot] = snapshots[table_level][r.slot];
      REQ_WRITE: begin
        slot_masks[r.slot] = r.mask_value;
        alloc_bits[r.slot] = r.slot_allocated;
      end
      default: ;
    endcase
    rsp.slot_mask   = slot_masks[r.slot];
    rsp.stack_level = LVL_O_W'(table_level);
    rsp.status      = st;
    return rsp;
  endfunction

  function automatic msstk_req_t make_req(logic [REQ_W-1:0] kind, logic [SLOT_W-1:0] s,
                                          logic [MASK_W-1:0] v, logic a);
    msstk_req_t r;
    r.req_type       = kind;
    r.slot           = s;
    r.mask_value     = v;
    r.slot_allocated = a;
    return r;
  endfunction

  // random request: pushes slightly outnumber pops so the level walks up and
  // down through overflow and underflow; half the slots fall in a small window
  // so reads, saves and restores mostly hit slots that were written
  function automatic msstk_req_t random_request();
    msstk_req_t r;
    int         pick;
    pick             = $urandom_range(99);
    r.slot           = ($urandom_range(1) != 0) ? SLOT_W'($urandom_range(7))
                                                : SLOT_W'($urandom_range(TASKS - 1));
    r.mask_value     = MASK_W'($urandom_range(255));
    r.slot_allocated = ($urandom_range(9) < 7);
    if (pick < 12) begin
      r.req_type = REQ_LEVEL;
    end else if (pick < 20) begin
      r.req_type   = REQ_LEVEL;
      r.mask_value = POP_VALUE;
    end else if (pick < 30) begin
      r.req_type = REQ_SAVE;
    end else if (pick < 40) begin
      r.req_type = REQ_RESTORE;
    end else if (pick < 70) begin
      r.req_type = REQ_WRITE;
    end else if (pick < 95) begin
      r.req_type = REQ_READ;
    end else begin
      r.req_type = REQ_W'($urandom_range(REQ_TOP, REQ_READ + 1));
    end
    return r;
  endfunction

  // driver: a new item only after the previous one was taken, never
  // depending on the current stall; stalls are redrawn every cycle
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (request_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_data  <= request_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // monitor: check taken results in order, predict each accepted item
  always @(posedge clk) begin : check_results
    msstk_rsp_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result %h with no item outstanding", out_data);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data.slot_mask !== want.slot_mask) begin
            $error("slot_mask expected %h got %h", want.slot_mask, out_data.slot_mask);
            fails++;
          end
          if (out_data.stack_level !== want.stack_level) begin
            $error("stack_level expected %0d got %0d", want.stack_level, out_data.stack_level);
            fails++;
          end
          if (out_data.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_data.status);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) awaited_results.push_back(step_mask_table(in_data));
    end
    in_taken <= in_valid && !in_stall;
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int p;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    in_taken    = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    fails       = 0;
    cycle_count = 0;
    table_level = 0;
    for (i = 0; i < TASKS; i++) begin
      slot_masks[i] = '0;
      alloc_bits[i] = 1'b0;
      for (p = 0; p < DEPTH; p++) snapshots[p][i] = '0;
    end

    // directed part
    // reset state, then extremes of slot and mask with both flag values
    request_queue.push_back(make_req(REQ_READ,    0,         '0,        1'b0));
    request_queue.push_back(make_req(REQ_WRITE,   0,         ALL_ONES,  1'b1));
    request_queue.push_back(make_req(REQ_WRITE,   LAST_SLOT, '0,        1'b1));
    request_queue.push_back(make_req(REQ_WRITE,   5,         8'h12,     1'b0));
    request_queue.push_back(make_req(REQ_WRITE,   6,         8'h01,     1'b1));
    // save and restore at level zero work on the row no push fills
    request_queue.push_back(make_req(REQ_SAVE,    0,         '0,        1'b0));
    request_queue.push_back(make_req(REQ_RESTORE, 6,         '0,        1'b0));
    request_queue.push_back(make_req(REQ_RESTORE, 0,         '0,        1'b0));
    // pop at level zero underflows
    request_queue.push_back(make_req(REQ_LEVEL,   1,         POP_VALUE, 1'b0));
    // push with a free slot exempt: it keeps its mask instead of clearing
    request_queue.push_back(make_req(REQ_LEVEL,   5,         8'h80,     1'b0));
    request_queue.push_back(make_req(REQ_READ,    LAST_SLOT, '0,        1'b0));
    request_queue.push_back(make_req(REQ_LEVEL,   LAST_SLOT, 8'h01,     1'b1));
    request_queue.push_back(make_req(REQ_LEVEL,   0,         ALL_ONES,  1'b0));
    // full stack overflows
    request_queue.push_back(make_req(REQ_LEVEL,   2,         8'h40,     1'b1));
    request_queue.push_back(make_req(REQ_SAVE,    LAST_SLOT, '0,        1'b0));
    request_queue.push_back(make_req(REQ_WRITE,   LAST_SLOT, 8'h55,     1'b1));
    request_queue.push_back(make_req(REQ_RESTORE, LAST_SLOT, '0,        1'b0));
    // unwind all the way, the last pop underflows again
    request_queue.push_back(make_req(REQ_LEVEL,   LAST_SLOT, POP_VALUE, 1'b0));
    request_queue.push_back(make_req(REQ_LEVEL,   0,         POP_VALUE, 1'b1));
    request_queue.push_back(make_req(REQ_LEVEL,   6,         POP_VALUE, 1'b0));
    request_queue.push_back(make_req(REQ_LEVEL,   6,         POP_VALUE, 1'b0));
    // spare request codes
    for (i = REQ_READ + 1; i <= REQ_TOP; i++)
      request_queue.push_back(make_req(REQ_W'(i), LAST_SLOT, 8'hAA, 1'b1));
    request_queue.push_back(make_req(REQ_READ,    5,         '0,        1'b0));

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // random part in idling phases; the sender drains fully between phases
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 73; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      for (i = 0; i < RANDOM_PER_PHASE; i++) request_queue.push_back(random_request());
      while (request_queue.size() != 0 || in_valid || awaited_results.size() != 0)
        @(posedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
